// ----- hw/rtl/sha_pkg.sv -----
package sha_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned Rounds  = 64;
    localparam int unsigned BlockWd = 16;

    // pad word that follows a message ending on a word boundary
    localparam logic [WordW-1:0] PadWord = 32'h8000_0000;

    // control from the padding sequencer to the compression unit
    typedef struct packed {
        logic             load;
        logic [WordW-1:0] word;
        logic             start;
        logic             chain_init;
    } t_cmp_ctl;

    // status back from the compression unit
    typedef struct packed {
        logic done;
    } t_cmp_sts;

    typedef logic [7:0][WordW-1:0] t_chain;

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic logic [WordW-1:0] big_sig0(input logic [WordW-1:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WordW-1:0] big_sig1(input logic [WordW-1:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WordW-1:0] small_sig0(input logic [WordW-1:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WordW-1:0] small_sig1(input logic [WordW-1:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // initial hash values
    function automatic logic [WordW-1:0] hash_iv(input logic [2:0] idx);
        case (idx)
            3'd0:    hash_iv = 32'h6a09e667;
            3'd1:    hash_iv = 32'hbb67ae85;
            3'd2:    hash_iv = 32'h3c6ef372;
            3'd3:    hash_iv = 32'ha54ff53a;
            3'd4:    hash_iv = 32'h510e527f;
            3'd5:    hash_iv = 32'h9b05688c;
            3'd6:    hash_iv = 32'h1f83d9ab;
            default: hash_iv = 32'h5be0cd19;
        endcase
    endfunction

    // round constants
    function automatic logic [WordW-1:0] round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

// ----- hw/rtl/sha_compress.sv -----
module sha_compress import sha_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmp_ctl i_ctl,
    output t_cmp_sts o_sts,
    output t_chain   o_chain
);

    t_chain                     r_chain;
    t_chain                     r_var;
    logic [BlockWd-1:0][WordW-1:0] r_win;
    logic                       r_busy;
    logic                       r_add;
    logic                       r_done;
    logic [5:0]                 r_round;

    logic [WordW-1:0] new_w;
    logic [WordW-1:0] t1;
    logic [WordW-1:0] t2;
    logic [WordW-1:0] ch;
    logic [WordW-1:0] maj;

    // schedule: window slot 0 holds the current round word
    assign new_w = small_sig1(r_win[14]) + r_win[9] + small_sig0(r_win[1]) + r_win[0];

    // one round of the shared round unit
    assign ch  = (r_var[4] & r_var[5]) ^ (~r_var[4] & r_var[6]);
    assign maj = (r_var[0] & r_var[1]) ^ (r_var[0] & r_var[2]) ^ (r_var[1] & r_var[2]);
    assign t1  = r_var[7] + big_sig1(r_var[4]) + ch + round_k(r_round) + r_win[0];
    assign t2  = big_sig0(r_var[0]) + maj;

    // round sequencer and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_add   <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= hash_iv(3'(i));
            end
        end else begin
            r_done <= 1'b0;
            if (i_ctl.chain_init) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= hash_iv(3'(i));
                end
            end
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'(Rounds - 1)) begin
                    r_busy <= 1'b0;
                    r_add  <= 1'b1;
                end
            end else if (r_add) begin
                r_add  <= 1'b0;
                r_done <= 1'b1;
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_var[i];
                end
            end
        end
    end

    // window shift and working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_win <= {i_ctl.word, r_win[BlockWd-1:1]};
        end else if (r_busy) begin
            r_win <= {new_w, r_win[BlockWd-1:1]};
        end
        if (i_ctl.start) begin
            r_var <= r_chain;
        end else if (r_busy) begin
            r_var[7] <= r_var[6];
            r_var[6] <= r_var[5];
            r_var[5] <= r_var[4];
            r_var[4] <= r_var[3] + t1;
            r_var[3] <= r_var[2];
            r_var[2] <= r_var[1];
            r_var[1] <= r_var[0];
            r_var[0] <= t1 + t2;
        end
    end

    assign o_sts.done = r_done;
    assign o_chain    = r_chain;

endmodule

// ----- hw/rtl/sha256_hash_core.sv -----
// non-final item: pushed into the window when accepted; an item that fills a 16-word block
// then takes 64 rounds on the shared round unit, one chaining add and one handoff
// final item: pad words are pushed in turn, each block that padding produces is compressed,
// then the eight digest items, one per cycle when the sink is ready
// sustained rate is set by one round per cycle; no item is accepted while a block is compressed
// reset: synchronous active low, chaining value to the initial hash, block idle
module sha256_hash_core import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_final_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_BUSY = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state      r_state;
    logic [3:0]  r_cnt;
    logic [63:0] r_len;
    logic        r_fin;
    logic        r_need80;
    logic        r_hi_done;
    logic        r_lo_done;
    logic [2:0]  r_idx;

    logic             in_acc;
    logic             out_acc;
    logic             push;
    logic [WordW-1:0] pword;
    logic [2:0]       nb;
    logic [WordW-1:0] fin_word;
    logic [6:0]       len_add;
    t_cmp_ctl         ctl;
    t_cmp_sts         sts;
    t_chain           chain;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign out_acc     = o_out_valid & i_out_ready;

    // clamp byte count and place the pad byte on a final item
    assign nb = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
    always_comb begin
        case (nb)
            3'd0:    fin_word = PadWord;
            3'd1:    fin_word = {i_message_word[31:24], 24'h80_0000};
            3'd2:    fin_word = {i_message_word[31:16], 16'h8000};
            3'd3:    fin_word = {i_message_word[31:8], 8'h80};
            default: fin_word = i_message_word;
        endcase
    end
    assign len_add = i_final_word ? {1'b0, nb, 3'b000} : 7'd32;

    // word pushed into the schedule window this cycle
    always_comb begin
        push  = 1'b0;
        pword = '0;
        if (in_acc) begin
            push  = 1'b1;
            pword = i_final_word ? fin_word : i_message_word;
        end else if (r_state == S_PAD) begin
            push = 1'b1;
            if (r_need80) begin
                pword = PadWord;
            end else if (r_hi_done) begin
                pword = r_len[31:0];
            end else if (r_cnt == 4'd14) begin
                pword = r_len[63:32];
            end
        end
    end

    assign ctl.load       = push;
    assign ctl.word       = pword;
    assign ctl.start      = push && (r_cnt == 4'(BlockWd - 1));
    assign ctl.chain_init = out_acc && (r_idx == 3'd7);

    sha_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_chain (chain)
    );

    // padding sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_len     <= '0;
            r_fin     <= 1'b0;
            r_need80  <= 1'b0;
            r_hi_done <= 1'b0;
            r_lo_done <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (push) begin
                r_cnt <= r_cnt + 4'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_len    <= r_len + 64'(len_add);
                        r_fin    <= i_final_word;
                        r_need80 <= i_final_word && (nb == 3'd4);
                        if (ctl.start) begin
                            r_state <= S_BUSY;
                        end else if (i_final_word) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (r_need80) begin
                        r_need80 <= 1'b0;
                    end else if (r_hi_done) begin
                        r_lo_done <= 1'b1;
                    end else if (r_cnt == 4'd14) begin
                        r_hi_done <= 1'b1;
                    end
                    if (ctl.start) begin
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (sts.done) begin
                        if (r_lo_done) begin
                            r_state <= S_OUT;
                        end else if (r_fin) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_state   <= S_IDLE;
                            r_len     <= '0;
                            r_fin     <= 1'b0;
                            r_hi_done <= 1'b0;
                            r_lo_done <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // digest items straight from the held chaining value
    assign o_digest_word = chain[r_idx];
    assign o_digest_last = (r_idx == 3'd7);

endmodule
